### hdl/tsopm_pkg.sv
// Shared types, constants and codes for the timestamp-ordered pair matcher.
package tsopm_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int ID_W        = 4;
    localparam int TIME_W      = 31;

    typedef enum logic [1:0] {
        M_ADD     = 2'd0,
        M_CONFIRM = 2'd1,
        M_TRY     = 2'd2,
        M_CLEAR   = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_PC_INIT,
        S_PC_RD,
        S_PC_CMP,
        S_DR_RD,
        S_DR_CMP,
        S_FIN
    } t_state;

    // One input request
    typedef struct packed {
        t_mode             mode;
        logic [ID_W-1:0]   entry_id;
        logic [TIME_W-1:0] entry_time;
        logic [ID_W-1:0]   second_id;
        logic              waiting;
    } t_in_req;

    // One result
    typedef struct packed {
        logic              paired_now;
        logic [ID_W-1:0]   partner;
        logic              send_confirm;
        logic              is_paired;
        logic [CNT_W-1:0]  list_count;
        logic              overflow;
    } t_out_res;

    // One ready list entry
    typedef struct packed {
        logic [TIME_W-1:0] t;
        logic [ID_W-1:0]   id;
    } t_entry;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        t_entry            wdata;
        logic [IDX_W-1:0]  raddr;
    } t_mem_req;

    typedef struct packed {
        t_entry            key;
        logic [ID_W-1:0]   id_a;
        logic [ID_W-1:0]   id_b;
    } t_cmp_req;

    typedef struct packed {
        logic lt;
        logic hit_a;
        logic hit_b;
    } t_cmp_res;

endpackage

### hdl/tsopm_mem.sv
// Ready list storage: one write port, one registered read port.
module tsopm_mem (
    input  logic                i_clk,
    input  tsopm_pkg::t_mem_req i_req,
    output tsopm_pkg::t_entry   o_rdata
);
    import tsopm_pkg::*;

    t_entry r_mem [MAX_ENTRIES];
    t_entry r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/tsopm_cmp.sv
// Shared compare unit: key ordering and id matches against one list entry.
module tsopm_cmp (
    input  tsopm_pkg::t_cmp_req i_req,
    input  tsopm_pkg::t_entry   i_entry,
    output tsopm_pkg::t_cmp_res o_res
);
    import tsopm_pkg::*;

    // (time, id) ordering, ties go to the smaller id
    assign o_res.lt    = (i_req.key.t < i_entry.t) ||
                         ((i_req.key.t == i_entry.t) && (i_req.key.id < i_entry.id));
    assign o_res.hit_a = (i_entry.id == i_req.id_a);
    assign o_res.hit_b = (i_entry.id == i_req.id_b);

endmodule

### hdl/tsopm_ctrl.sv
// Sequencer: insert, pairing scan and compaction over the ready list.
module tsopm_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  tsopm_pkg::t_in_req            i_in_data,
    input  logic [tsopm_pkg::ID_W-1:0]    i_own_id,
    input  logic                          i_out_free,
    output logic                          o_done,
    output tsopm_pkg::t_out_res           o_res,
    output tsopm_pkg::t_mem_req           o_mem_req,
    input  tsopm_pkg::t_entry             i_rdata,
    output tsopm_pkg::t_cmp_req           o_cmp_req,
    input  tsopm_pkg::t_cmp_res           i_cmp_res
);
    import tsopm_pkg::*;

    t_state            r_state,  n_state;
    logic [CNT_W-1:0]  r_count,  n_count;
    logic              r_paired, n_paired;
    logic [ID_W-1:0]   r_partner, n_partner;
    logic [CNT_W-1:0]  r_idx,    n_idx;
    logic [CNT_W-1:0]  r_dst,    n_dst;
    t_entry            r_key,    n_key;
    logic              r_was_paired, n_was_paired;
    logic              r_sent,   n_sent;
    logic              r_ovf,    n_ovf;
    logic              r_pc_after, n_pc_after;
    logic [ID_W-1:0]   r_drop_a, n_drop_a;
    logic [ID_W-1:0]   r_drop_b, n_drop_b;
    logic [ID_W-1:0]   r_prev_id, n_prev_id;

    logic [CNT_W-1:0]  idx_dec;
    logic [CNT_W-1:0]  idx_inc;
    logic [CNT_W-1:0]  cnt_inc;
    logic [CNT_W-1:0]  dst_inc;

    assign idx_dec = r_idx - 1'b1;
    assign idx_inc = r_idx + 1'b1;
    assign cnt_inc = r_count + 1'b1;
    assign dst_inc = r_dst + 1'b1;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_paired  <= 1'b0;
            r_partner <= '0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_paired  <= n_paired;
            r_partner <= n_partner;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_dst        <= n_dst;
        r_key        <= n_key;
        r_was_paired <= n_was_paired;
        r_sent       <= n_sent;
        r_ovf        <= n_ovf;
        r_pc_after   <= n_pc_after;
        r_drop_a     <= n_drop_a;
        r_drop_b     <= n_drop_b;
        r_prev_id    <= n_prev_id;
    end

    // Next state and datapath control
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_paired     = r_paired;
        n_partner    = r_partner;
        n_idx        = r_idx;
        n_dst        = r_dst;
        n_key        = r_key;
        n_was_paired = r_was_paired;
        n_sent       = r_sent;
        n_ovf        = r_ovf;
        n_pc_after   = r_pc_after;
        n_drop_a     = r_drop_a;
        n_drop_b     = r_drop_b;
        n_prev_id    = r_prev_id;
        o_mem_req.we    = 1'b0;
        o_mem_req.waddr = r_idx[IDX_W-1:0];
        o_mem_req.wdata = r_key;
        o_mem_req.raddr = r_idx[IDX_W-1:0];
        o_done       = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_key.t      = i_in_data.entry_time;
                    n_key.id     = i_in_data.entry_id;
                    n_was_paired = r_paired;
                    n_sent       = 1'b0;
                    n_ovf        = 1'b0;
                    n_pc_after   = 1'b0;
                    case (i_in_data.mode)
                        M_ADD: begin
                            n_pc_after = i_in_data.waiting;
                            if (r_count >= CNT_W'(MAX_ENTRIES)) begin
                                n_ovf   = 1'b1;
                                n_state = i_in_data.waiting ? S_PC_INIT : S_FIN;
                            end else begin
                                n_idx   = r_count;
                                n_state = S_INS_RD;
                            end
                        end
                        M_CONFIRM: begin
                            n_drop_a = i_in_data.entry_id;
                            n_drop_b = i_in_data.second_id;
                            if (i_own_id == i_in_data.entry_id ||
                                i_own_id == i_in_data.second_id) begin
                                n_partner = (i_own_id == i_in_data.entry_id) ?
                                            i_in_data.second_id : i_in_data.entry_id;
                                n_paired  = 1'b1;
                            end else begin
                                n_pc_after = i_in_data.waiting;
                            end
                            n_idx   = '0;
                            n_dst   = '0;
                            n_state = S_DR_RD;
                        end
                        M_TRY: begin
                            n_state = S_PC_INIT;
                        end
                        M_CLEAR: begin
                            n_paired = 1'b0;
                            n_state  = S_FIN;
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end

            // Insert: walk back from the tail, shifting larger entries up
            S_INS_RD: begin
                if (r_idx == '0) begin
                    o_mem_req.we    = 1'b1;
                    o_mem_req.waddr = '0;
                    n_count         = cnt_inc;
                    n_state         = r_pc_after ? S_PC_INIT : S_FIN;
                end else begin
                    o_mem_req.raddr = idx_dec[IDX_W-1:0];
                    n_state         = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                o_mem_req.we = 1'b1;
                if (i_cmp_res.lt) begin
                    o_mem_req.wdata = i_rdata;
                    n_idx           = idx_dec;
                    n_state         = S_INS_RD;
                end else begin
                    n_count = cnt_inc;
                    n_state = r_pc_after ? S_PC_INIT : S_FIN;
                end
            end

            // Pairing scan: find own id, pair with predecessor at even position
            S_PC_INIT: begin
                n_pc_after = 1'b0;
                n_drop_a   = i_own_id;
                n_drop_b   = i_own_id;
                n_idx      = '0;
                n_state    = r_paired ? S_FIN : S_PC_RD;
            end
            S_PC_RD: begin
                if (r_idx == r_count) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_PC_CMP;
                end
            end
            S_PC_CMP: begin
                if (i_cmp_res.hit_a) begin
                    if (r_idx[0]) begin
                        n_partner = r_prev_id;
                        n_paired  = 1'b1;
                        n_sent    = 1'b1;
                        n_drop_b  = r_prev_id;
                        n_idx     = '0;
                        n_dst     = '0;
                        n_state   = S_DR_RD;
                    end else begin
                        n_state = S_FIN;
                    end
                end else begin
                    n_prev_id = i_rdata.id;
                    n_idx     = idx_inc;
                    n_state   = S_PC_RD;
                end
            end

            // Compaction: keep entries matching neither id
            S_DR_RD: begin
                if (r_idx == r_count) begin
                    n_count    = r_dst;
                    n_pc_after = 1'b0;
                    n_state    = r_pc_after ? S_PC_INIT : S_FIN;
                end else begin
                    n_state = S_DR_CMP;
                end
            end
            S_DR_CMP: begin
                if (!i_cmp_res.hit_a && !i_cmp_res.hit_b) begin
                    o_mem_req.we    = 1'b1;
                    o_mem_req.waddr = r_dst[IDX_W-1:0];
                    o_mem_req.wdata = i_rdata;
                    n_dst           = dst_inc;
                end
                n_idx   = idx_inc;
                n_state = S_DR_RD;
            end

            // Hand the result to the output register
            S_FIN: begin
                if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    assign o_cmp_req.key  = r_key;
    assign o_cmp_req.id_a = r_drop_a;
    assign o_cmp_req.id_b = r_drop_b;

    assign o_res.paired_now   = !r_was_paired && r_paired;
    assign o_res.partner      = r_paired ? r_partner : '0;
    assign o_res.send_confirm = r_sent;
    assign o_res.is_paired    = r_paired;
    assign o_res.list_count   = r_count;
    assign o_res.overflow     = r_ovf;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ENTRIES))
        else $error("ready list count beyond capacity");

    a_dst_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DR_RD || r_state == S_DR_CMP) |-> (r_dst <= r_idx))
        else $error("compaction write pointer ahead of read pointer");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> (r_state != S_IDLE))
        else $error("accepted request did not start the sequencer");

    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_req.we |-> (r_state == S_INS_RD || r_state == S_INS_CMP ||
                          r_state == S_DR_CMP))
        else $error("list write outside insert or compaction");

endmodule

### hdl/timestamp_ordered_pair_matcher_top.sv
// Top level of the timestamp-ordered pair matcher.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+--------------------------
//  in      | into      | i_in_valid / o_in_stall  | i_in_data  (t_in_req)
//  out     | out of    | o_out_valid / i_out_stall| o_out_data (t_out_res)
//  cfg     | into      | i_cfg_we                 | i_cfg_wdata (own id)
//
// One request at a time; o_in_stall is high while the sequencer works.
// An add inserts into the list unless it is full, a confirm compacts it and a try
// runs a pairing scan; a pairing hit adds a compaction pass, and an add or foreign
// confirm with waiting set adds a pairing scan. Each list element is read through
// the single registered read port of the list memory. A clear keeps the list.
// Synchronous active-low reset empties the list and drops the paired mark.
// A finished result sits in the output register while the next request is
// taken; the sequencer holds its result only if that register is still full.
module timestamp_ordered_pair_matcher_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tsopm_pkg::ID_W-1:0]    i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  tsopm_pkg::t_in_req            i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output tsopm_pkg::t_out_res           o_out_data
);
    import tsopm_pkg::*;

    logic [ID_W-1:0] r_own_id;
    logic            r_out_valid;
    t_out_res        r_out_data;

    logic            out_free;
    logic            done;
    t_out_res        res;
    t_mem_req        mem_req;
    t_entry          rdata;
    t_cmp_req        cmp_req;
    t_cmp_res        cmp_res;

    // Own id register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_id <= '0;
        end else if (i_cfg_we) begin
            r_own_id <= i_cfg_wdata;
        end
    end

    // Output register
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    tsopm_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (rdata)
    );

    tsopm_cmp u_cmp (
        .i_req   (cmp_req),
        .i_entry (rdata),
        .o_res   (cmp_res)
    );

    tsopm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_own_id   (r_own_id),
        .i_out_free (out_free),
        .o_done     (done),
        .o_res      (res),
        .o_mem_req  (mem_req),
        .i_rdata    (rdata),
        .o_cmp_req  (cmp_req),
        .i_cmp_res  (cmp_res)
    );

    a_paired_now_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.paired_now) |-> o_out_data.is_paired)
        else $error("paired_now without paired mark");

    a_send_is_new_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.send_confirm) |-> o_out_data.paired_now)
        else $error("send_confirm without a new pair");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |-> out_free)
        else $error("result finished while output register full");

endmodule

### test/tb.sv
// Testbench for the timestamp-ordered pair matcher: directed and random requests checked per field.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tsopm_pkg::*;

    localparam int SETTLE_CYCLES   = 150;
    localparam int ITEMS_PER_PHASE = 280;
    localparam int RANDOM_PHASES   = 6;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_cfg_we    = 1'b0;
    logic [ID_W-1:0]   i_cfg_wdata = '0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_stall;
    t_in_req           i_in_data   = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    t_out_res          o_out_data;

    timestamp_ordered_pair_matcher_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // Requests waiting to be driven, and results the matcher still owes us
    t_in_req     pending[$];
    t_out_res    awaited[$];
    int unsigned n_issued = 0;
    int unsigned n_taken  = 0;
    int          errors   = 0;

    // Run statistics
    int mode_seen[4]     = '{0, 0, 0, 0};
    int pairs_formed     = 0;
    int dropped_adds     = 0;

    // Idle burst control, set per phase
    int idle_pct  = 0;
    int stall_pct = 0;
    int gap_left  = 0;
    int stall_left = 0;

    // Mirror of the matcher state
    logic [ID_W-1:0]   list_ids   [MAX_ENTRIES];
    logic [TIME_W-1:0] list_times [MAX_ENTRIES];
    int                list_len = 0;
    logic              paired   = 1'b0;
    logic [ID_W-1:0]   mate_id  = '0;
    logic [ID_W-1:0]   self_id  = '0;

    // Drop every entry carrying either id, keeping the order
    function automatic void list_remove(logic [ID_W-1:0] a, logic [ID_W-1:0] b);
        int kept;
        kept = 0;
        for (int i = 0; i < list_len; i++) begin
            if (list_ids[i] != a && list_ids[i] != b) begin
                list_ids[kept]   = list_ids[i];
                list_times[kept] = list_times[i];
                kept++;
            end
        end
        list_len = kept;
    endfunction

    // Sorted insert by (time, id); returns 0 when the list is full
    function automatic bit list_add(logic [ID_W-1:0] id, logic [TIME_W-1:0] ts);
        int slot;
        if (list_len >= MAX_ENTRIES) begin
            return 1'b0;
        end
        slot = list_len;
        for (int i = 0; i < list_len; i++) begin
            if (ts < list_times[i] || (ts == list_times[i] && id < list_ids[i])) begin
                slot = i;
                break;
            end
        end
        for (int i = list_len; i > slot; i--) begin
            list_ids[i]   = list_ids[i-1];
            list_times[i] = list_times[i-1];
        end
        list_ids[slot]   = id;
        list_times[slot] = ts;
        list_len++;
        return 1'b1;
    endfunction

    // Pair with the predecessor when our own first entry sits at an even position
    function automatic bit try_pair();
        int              pos;
        logic [ID_W-1:0] mate;
        if (paired) begin
            return 1'b0;
        end
        pos = 0;
        for (int i = 0; i < list_len; i++) begin
            if (list_ids[i] == self_id) begin
                pos = i + 1;
                break;
            end
        end
        if (pos == 0 || pos % 2 == 1) begin
            return 1'b0;
        end
        mate    = list_ids[pos-2];
        paired  = 1'b1;
        mate_id = mate;
        list_remove(self_id, mate);
        return 1'b1;
    endfunction

    // Advance the mirror by one request and build the result it should produce
    function automatic t_out_res match_step(t_in_req rq);
        t_out_res res;
        logic     was_paired;
        was_paired = paired;
        res = '0;
        case (rq.mode)
            M_ADD: begin
                res.overflow = !list_add(rq.entry_id, rq.entry_time);
                if (rq.waiting) begin
                    res.send_confirm = try_pair();
                end
            end
            M_CONFIRM: begin
                if (self_id == rq.entry_id || self_id == rq.second_id) begin
                    mate_id = (self_id == rq.entry_id) ? rq.second_id : rq.entry_id;
                    paired  = 1'b1;
                    list_remove(rq.entry_id, rq.second_id);
                end else begin
                    list_remove(rq.entry_id, rq.second_id);
                    if (rq.waiting) begin
                        res.send_confirm = try_pair();
                    end
                end
            end
            M_TRY: begin
                res.send_confirm = try_pair();
            end
            M_CLEAR: begin
                paired = 1'b0;
            end
            default: begin
            end
        endcase
        res.paired_now = !was_paired && paired;
        res.partner    = paired ? mate_id : '0;
        res.is_paired  = paired;
        res.list_count = CNT_W'(list_len);
        return res;
    endfunction

    function automatic t_in_req make_request(t_mode m, logic [ID_W-1:0] id,
                                             logic [TIME_W-1:0] ts, logic [ID_W-1:0] id2,
                                             logic w);
        t_in_req rq;
        rq.mode       = m;
        rq.entry_id   = id;
        rq.entry_time = ts;
        rq.second_id  = id2;
        rq.waiting    = w;
        return rq;
    endfunction

    // Favor our own id so that pairings actually happen
    function automatic logic [ID_W-1:0] pick_id(logic [ID_W-1:0] own);
        if ($urandom_range(2) == 0) begin
            return own;
        end
        return ID_W'($urandom_range(15));
    endfunction

    // Mix of extremes, tie-prone small stamps and full-range stamps
    function automatic logic [TIME_W-1:0] pick_time();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            2, 3:    return TIME_W'($urandom_range(15));
            default: return TIME_W'($urandom);
        endcase
    endfunction

    function automatic t_in_req random_request(int add_pct, int wait_pct, logic [ID_W-1:0] own);
        int    roll;
        t_mode m;
        roll = $urandom_range(99);
        if (roll < add_pct) begin
            m = M_ADD;
        end else begin
            roll = $urandom_range(9);
            if (roll < 4) begin
                m = M_CONFIRM;
            end else if (roll < 7) begin
                m = M_TRY;
            end else begin
                m = M_CLEAR;
            end
        end
        return make_request(m, pick_id(own), pick_time(), pick_id(own),
                            $urandom_range(99) < wait_pct);
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // Clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Request driver: one request at a time, held until taken
    always @(negedge i_clk) begin
        if (n_taken == n_issued) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pending.size() > 0 && $urandom_range(99) < idle_pct) begin
                gap_left = $urandom_range(8);
                i_in_valid <= 1'b0;
            end else if (pending.size() > 0) begin
                i_in_data  <= pending.pop_front();
                i_in_valid <= 1'b1;
                n_issued++;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result-side backpressure in bursts
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(99) < stall_pct) begin
            stall_left = $urandom_range(8);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Monitor: track config, predict taken requests, check delivered results
    always @(posedge i_clk) begin
        t_out_res want;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                self_id = i_cfg_wdata;
            end
            if (i_in_valid && !o_in_stall) begin
                awaited.push_back(match_step(i_in_data));
                mode_seen[i_in_data.mode]++;
                n_taken++;
            end
            if (o_out_valid && !i_out_stall) begin
                if (awaited.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, actual %p",
                             $time, o_out_data);
                    errors++;
                end else begin
                    want = awaited.pop_front();
                    pairs_formed += want.send_confirm;
                    dropped_adds += want.overflow;
                    check_field("paired_now",   want.paired_now,   o_out_data.paired_now);
                    check_field("partner",      want.partner,      o_out_data.partner);
                    check_field("send_confirm", want.send_confirm, o_out_data.send_confirm);
                    check_field("is_paired",    want.is_paired,    o_out_data.is_paired);
                    check_field("list_count",   want.list_count,   o_out_data.list_count);
                    check_field("overflow",     want.overflow,     o_out_data.overflow);
                end
            end
        end
    end

    // Let everything in flight come back, then give the sequencer time to go idle
    task automatic drain();
        while (pending.size() != 0 || n_taken != n_issued || awaited.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_own(logic [ID_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Stimulus sequence
    initial begin
        int              own_for   [RANDOM_PHASES] = '{15, 0, 7, 0, 0, 10};
        int              add_for   [RANDOM_PHASES] = '{50, 75, 45, 60, 40, 55};
        int              wait_for  [RANDOM_PHASES] = '{70, 30, 80, 50, 90, 60};
        int              idle_for  [RANDOM_PHASES] = '{30, 20, 0, 40, 25, 0};
        int              stall_for [RANDOM_PHASES] = '{10, 6, 0, 15, 8, 0};
        logic [ID_W-1:0] own;

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, own id 5
        own = 4'd5;
        write_own(own);
        idle_pct  = 20;
        stall_pct = 8;
        // Own entry lands second with the largest stamp: pairs with id 3
        pending.push_back(make_request(M_ADD, 4'd3, 31'd10, 4'd0, 1'b0));
        pending.push_back(make_request(M_ADD, own, '1, 4'd0, 1'b1));
        pending.push_back(make_request(M_CLEAR, 4'd0, '0, 4'd0, 1'b0));
        // Try on an empty list does nothing
        pending.push_back(make_request(M_TRY, 4'd0, '0, 4'd0, 1'b0));
        // Confirm naming us, then again while already paired
        pending.push_back(make_request(M_CONFIRM, own, '0, 4'd9, 1'b0));
        pending.push_back(make_request(M_CONFIRM, 4'd2, '0, own, 1'b1));
        pending.push_back(make_request(M_CLEAR, 4'd0, '0, 4'd0, 1'b0));
        // Confirm naming us twice makes us our own partner
        pending.push_back(make_request(M_CONFIRM, own, '0, own, 1'b0));
        pending.push_back(make_request(M_CLEAR, 4'd15, '1, 4'd15, 1'b1));
        // Duplicate ids all go on one foreign confirm
        pending.push_back(make_request(M_ADD, 4'd7, 31'd5, 4'd0, 1'b0));
        pending.push_back(make_request(M_ADD, 4'd7, 31'd6, 4'd0, 1'b0));
        pending.push_back(make_request(M_ADD, 4'd7, 31'd4, 4'd0, 1'b0));
        pending.push_back(make_request(M_CONFIRM, 4'd7, '0, 4'd7, 1'b1));
        // Fill the list with equal stamps, ties ordered by id
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            pending.push_back(make_request(M_ADD, ID_W'(i), '0, 4'd0, 1'b0));
        end
        // Add to a full list: dropped, yet the pairing check still runs
        pending.push_back(make_request(M_ADD, 4'd12, '0, 4'd0, 1'b1));
        pending.push_back(make_request(M_CLEAR, 4'd0, '0, 4'd0, 1'b0));

        // Random phases, each with its own id and traffic mix; the last runs without idling
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            drain();
            own = (p == 3 || p == 4) ? ID_W'($urandom_range(15)) : ID_W'(own_for[p]);
            write_own(own);
            idle_pct  = idle_for[p];
            stall_pct = stall_for[p];
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                pending.push_back(random_request(add_for[p], wait_for[p], own));
            end
        end
        drain();

        $display("Run covered %0d requests (add %0d, confirm %0d, try %0d, clear %0d) under %0d own ids",
                 n_taken, mode_seen[M_ADD], mode_seen[M_CONFIRM], mode_seen[M_TRY],
                 mode_seen[M_CLEAR], RANDOM_PHASES + 1);
        $display("Pairs formed by the block: %0d, adds dropped on a full list: %0d, mismatches: %0d",
                 pairs_formed, dropped_adds, errors);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("Timeout with %0d requests pending and %0d results outstanding",
                 pending.size(), awaited.size());
        $display("Verification failed");
        $finish;
    end

endmodule
